[hdl/hdp_pkg.sv]
// Haversine distance unit: shared constants, arctangent table and widths.
// No dependencies.
package hdp_pkg;

  localparam int AngW  = 34;
  localparam int TabLen = 40;

  localparam logic signed [AngW-1:0] CordicGain = 34'sd652032875;
  localparam logic signed [AngW-1:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [AngW-1:0] HalfTurn = 34'sd2147483648;
  localparam logic [31:0] PiQ30 = 32'd3373259426;
  localparam logic [26:0] DistMax = 27'd52707179;
  localparam int SqrtSteps = 31;

  localparam logic [7:0] RegRadius = 8'd0;
  localparam logic [7:0] RegLimit  = 8'd1;

  function automatic logic signed [AngW-1:0] hdp_atan(input int idx);
    logic signed [AngW-1:0] v;
    case (idx)
      0: v = 34'sh20000000;  1: v = 34'sh12E4051E;  2: v = 34'sh09FB385B;
      3: v = 34'sh051111D4;  4: v = 34'sh028B0D43;  5: v = 34'sh0145D7E1;
      6: v = 34'sh00A2F61E;  7: v = 34'sh00517C55;  8: v = 34'sh0028BE53;
      9: v = 34'sh00145F2F;  10: v = 34'sh000A2F98; 11: v = 34'sh000517CC;
      12: v = 34'sh00028BE6; 13: v = 34'sh000145F3; 14: v = 34'sh0000A2FA;
      15: v = 34'sh0000517D; 16: v = 34'sh000028BE; 17: v = 34'sh0000145F;
      18: v = 34'sh00000A30; 19: v = 34'sh00000518; 20: v = 34'sh0000028C;
      21: v = 34'sh00000146; 22: v = 34'sh000000A3; 23: v = 34'sh00000051;
      24: v = 34'sh00000029; 25: v = 34'sh00000014; 26: v = 34'sh0000000A;
      27: v = 34'sh00000005; 28: v = 34'sh00000003; 29: v = 34'sh00000001;
      30: v = 34'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/haversine_distance_proximity_unit.sv]
// Throughput: one word per cycle while the output is not stalled; the rate is set
// by the unrolled CORDIC and root stages.
// A stalled output holds the whole pipeline in place; nothing is lost.
// Reset (rst_ni low, async) clears valid bits and loads radius 3522627, limit 307.
// Haversine distance top level: input folding, CORDIC, products, root, scaling.
// Depends on hdp_pkg, hdp_cordic_step, hdp_sqrt_step.
module haversine_distance_proximity_unit import hdp_pkg::*; #(
  parameter int CORDIC_STEPS = 30
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: first_latitude, first_longitude, second_latitude, second_longitude
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: distance[25:0], near_flag[26], zero fill
  output logic [31:0]  m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);

  localparam int N   = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;
  localparam int LAT = 2 * N + 37;

  logic en;
  logic [LAT-1:0] vld_q;
  logic [23:0] radius_q, limit_q;

  assign en = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      radius_q <= 24'd3522627;
      limit_q  <= 24'd307;
    end else begin
      if (en) vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
      if (cfg_valid_i && cfg_index_i == RegRadius) radius_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == RegLimit) limit_q <= cfg_data_i;
    end
  end

  // input stage: half differences and quadrant fold
  function automatic logic [AngW:0] fold(input logic [31:0] ang);
    logic signed [AngW-1:0] z;
    logic neg;
    z = AngW'(signed'(ang));
    neg = 1'b0;
    if (z > QuarterTurn) begin
      z = z - HalfTurn; neg = 1'b1;
    end else if (z < -QuarterTurn) begin
      z = z + HalfTurn; neg = 1'b1;
    end
    return {neg, z};
  endfunction

  logic [31:0] lat1, lon1, lat2, lon2, dlat, dlon;
  logic [AngW:0] f [4];
  logic signed [AngW-1:0] rx [0:N][4];
  logic signed [AngW-1:0] ry [0:N][4];
  logic signed [AngW-1:0] rz [0:N][4];
  logic [3:0] neg_q [0:N];

  assign lat1 = s_axis_tdata[31:0];
  assign lon1 = s_axis_tdata[63:32];
  assign lat2 = s_axis_tdata[95:64];
  assign lon2 = s_axis_tdata[127:96];
  assign dlat = lat2 - lat1;
  assign dlon = lon2 - lon1;
  assign f[0] = fold({dlat[31], dlat[31:1]});
  assign f[1] = fold({dlon[31], dlon[31:1]});
  assign f[2] = fold(lat1);
  assign f[3] = fold(lat2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        rx[0][l]    <= CordicGain;
        ry[0][l]    <= '0;
        rz[0][l]    <= f[l][AngW-1:0];
        neg_q[0][l] <= f[l][AngW];
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    for (genvar l = 0; l < 4; l++) begin : g_lane
      hdp_cordic_step #(.SHIFT(i), .VECTOR(1'b0)) u_step (
        .clk_i(clk_i), .en_i(en),
        .x_i(rx[i][l]), .y_i(ry[i][l]), .z_i(rz[i][l]),
        .x_o(rx[i+1][l]), .y_o(ry[i+1][l]), .z_o(rz[i+1][l])
      );
    end
    always_ff @(posedge clk_i) begin
      if (en) neg_q[i+1] <= neg_q[i];
    end
  end

  // squares and cosine product
  logic signed [AngW-1:0] s_lat, s_lon, c_1, c_2;
  logic signed [63:0] t1_q, t2_q, cc_q;
  assign s_lat = neg_q[N][0] ? -ry[N][0] : ry[N][0];
  assign s_lon = neg_q[N][1] ? -ry[N][1] : ry[N][1];
  assign c_1   = neg_q[N][2] ? -rx[N][2] : rx[N][2];
  assign c_2   = neg_q[N][3] ? -rx[N][3] : rx[N][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q <= (signed'(s_lat[31:0]) * signed'(s_lat[31:0])) >>> 30;
      t2_q <= (signed'(s_lon[31:0]) * signed'(s_lon[31:0])) >>> 30;
      cc_q <= (signed'(c_1[31:0]) * signed'(c_2[31:0])) >>> 30;
    end
  end

  logic signed [63:0] t1b_q, p_q, a_sum;
  always_ff @(posedge clk_i) begin
    if (en) begin
      t1b_q <= t1_q;
      p_q   <= (signed'(cc_q[31:0]) * signed'(t2_q[31:0])) >>> 30;
    end
  end

  // clamp a to [0,1] and set up both roots
  logic [30:0] a_c;
  logic [32:0] qrem [0:SqrtSteps][2];
  logic [30:0] qroot [0:SqrtSteps][2];
  logic [61:0] qrad [0:SqrtSteps][2];
  assign a_sum = t1b_q + p_q;
  always_comb begin
    if (a_sum < 0) a_c = '0;
    else if (a_sum > 64'sd1073741824) a_c = 31'd1073741824;
    else a_c = a_sum[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        qrem[0][l]  <= '0;
        qroot[0][l] <= '0;
      end
      qrad[0][0] <= {1'b0, a_c, 30'd0};
      qrad[0][1] <= {1'b0, 31'd1073741824 - a_c, 30'd0};
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    for (genvar l = 0; l < 2; l++) begin : g_lane
      hdp_sqrt_step u_step (
        .clk_i(clk_i), .en_i(en),
        .rem_i(qrem[k][l]), .root_i(qroot[k][l]), .rad_i(qrad[k][l]),
        .rem_o(qrem[k+1][l]), .root_o(qroot[k+1][l]), .rad_o(qrad[k+1][l])
      );
    end
  end

  // atan2 by vectoring: y = sqrt(a), x = sqrt(1-a)
  logic signed [AngW-1:0] vx [0:N];
  logic signed [AngW-1:0] vy [0:N];
  logic signed [AngW-1:0] vz [0:N];
  assign vx[0] = AngW'(qroot[SqrtSteps][1]);
  assign vy[0] = AngW'(qroot[SqrtSteps][0]);
  assign vz[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_vec
    hdp_cordic_step #(.SHIFT(i), .VECTOR(1'b1)) u_step (
      .clk_i(clk_i), .en_i(en),
      .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]),
      .x_o(vx[i+1]), .y_o(vy[i+1]), .z_o(vz[i+1])
    );
  end

  // central angle in radians, then distance
  logic [30:0] z_c;
  logic [62:0] crad_full;
  logic [32:0] crad_q;
  logic [56:0] dist_full;
  logic [26:0] dist_w, dist_sat;
  logic [25:0] dist_q;
  logic        near_q;

  always_comb begin
    if (vz[N] < 0) z_c = '0;
    else if (vz[N] > QuarterTurn) z_c = 31'd1073741824;
    else z_c = vz[N][30:0];
  end
  assign crad_full = z_c * PiQ30 + 63'd536870912;

  assign dist_full = radius_q * crad_q + 57'd536870912;
  assign dist_w    = dist_full[56:30];
  assign dist_sat  = (dist_w > DistMax) ? DistMax : dist_w;

  always_ff @(posedge clk_i) begin
    if (en) begin
      crad_q <= crad_full[62:30];
      dist_q <= dist_sat[25:0];
      near_q <= dist_sat < {3'd0, limit_q};
    end
  end

  assign m_axis_tdata = {5'd0, near_q, dist_q};

endmodule

[hdl/hdp_cordic_step.sv]
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// Depends on hdp_pkg.
module hdp_cordic_step import hdp_pkg::*; #(
  parameter int SHIFT  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [AngW-1:0] x_i,
  input  logic signed [AngW-1:0] y_i,
  input  logic signed [AngW-1:0] z_i,
  output logic signed [AngW-1:0] x_o,
  output logic signed [AngW-1:0] y_o,
  output logic signed [AngW-1:0] z_o
);

  localparam logic signed [AngW-1:0] Atan = hdp_atan(SHIFT);

  logic signed [AngW-1:0] x_q, y_q, z_q, x_d, y_d, z_d, dx, dy;
  logic                   pos;

  always_comb begin
    dx  = y_i >>> SHIFT;
    dy  = x_i >>> SHIFT;
    pos = VECTOR ? (y_i >= 0) : (z_i >= 0);
    if (VECTOR) begin
      if (pos) begin
        x_d = x_i + dx; y_d = y_i - dy; z_d = z_i + Atan;
      end else begin
        x_d = x_i - dx; y_d = y_i + dy; z_d = z_i - Atan;
      end
    end else begin
      if (pos) begin
        x_d = x_i - dx; y_d = y_i + dy; z_d = z_i - Atan;
      end else begin
        x_d = x_i + dx; y_d = y_i - dy; z_d = z_i + Atan;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

[hdl/hdp_sqrt_step.sv]
// One registered digit of a restoring integer square root (two radicand bits).
// Depends on hdp_pkg.
module hdp_sqrt_step import hdp_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [32:0] rem_i,
  input  logic [30:0] root_i,
  input  logic [61:0] rad_i,
  output logic [32:0] rem_o,
  output logic [30:0] root_o,
  output logic [61:0] rad_o
);

  logic [32:0] rem_q, rem_d, part, trial;
  logic [30:0] root_q, root_d;
  logic [61:0] rad_q;

  always_comb begin
    part  = {rem_i[30:0], rad_i[61:60]};
    trial = {root_i[30:0], 2'b01};
    if (part >= trial) begin
      rem_d  = part - trial;
      root_d = {root_i[29:0], 1'b1};
    end else begin
      rem_d  = part;
      root_d = {root_i[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= {rad_i[59:0], 2'b00};
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;

endmodule

[hdl/hdp_checker.sv]
// Port-level checks for the haversine distance unit, bound to the top level.
// Depends on hdp_pkg and haversine_distance_proximity_unit.
module hdp_checker import hdp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        cfg_ready_o
);

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> {1'b0, m_axis_tdata[25:0]} <= DistMax)
    else $error("distance above saturation bound");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind haversine_distance_proximity_unit hdp_checker u_hdp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tready(s_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .cfg_ready_o(cfg_ready_o)
);

[bench/tb.sv]
// Testbench for haversine_distance_proximity_unit: drives position pairs on the input
// stream, predicts distance and near flag with a fixed-point CORDIC model, checks outputs.
// Depends on hdp_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb;
  import hdp_pkg::*;

  localparam int Steps = 30;
  localparam int Latency = 2 * Steps + 37;

  typedef struct packed {
    logic [25:0] range_nm;
    logic        near;
  } dist_word_t;

  class dist_scoreboard;
    dist_word_t pending[$];
    int unsigned errors;
    int unsigned checked;
    logic [23:0] radius;
    logic [23:0] limit;

    function new();
      errors = 0;
      checked = 0;
      radius = 24'd3522627;
      limit = 24'd307;
    endfunction

    function automatic longint asr(longint v, int s);
      return v >>> s;
    endfunction

    function automatic void sin_cos(logic [31:0] ang, output longint s, output longint c);
      longint z, x, y, dx, dy;
      bit neg;
      z = longint'($signed(ang));
      neg = 0;
      x = CordicGain;
      y = 0;
      if (z > 64'sh40000000) begin
        z -= 64'sh80000000; neg = 1;
      end else if (z < -64'sh40000000) begin
        z += 64'sh80000000; neg = 1;
      end
      for (int i = 0; i < Steps; i++) begin
        dx = asr(y, i);
        dy = asr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(hdp_atan(i));
        end else begin
          x += dx; y -= dy; z += longint'(hdp_atan(i));
        end
      end
      s = neg ? -y : y;
      c = neg ? -x : x;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < Steps; i++) begin
        dx = asr(y, i);
        dy = asr(x, i);
        if (y >= 0) begin
          x += dx; y -= dy; z += longint'(hdp_atan(i));
        end else begin
          x -= dx; y += dy; z -= longint'(hdp_atan(i));
        end
      end
      if (z < 0) z = 0;
      if (z > 64'sh40000000) z = 64'sh40000000;
      return z;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b; r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function automatic logic [31:0] halve(logic [31:0] d);
      return {d[31], d[31:1]};
    endfunction

    function void note_pair(logic [31:0] lat1, logic [31:0] lon1,
                            logic [31:0] lat2, logic [31:0] lon2);
      longint sl, so, c1, c2, dm, a, cc, t1, t2, z;
      longint unsigned ra, rb, crad, dist_v;
      dist_word_t w;
      sin_cos(halve(lat2 - lat1), sl, dm);
      sin_cos(halve(lon2 - lon1), so, dm);
      sin_cos(lat1, dm, c1);
      sin_cos(lat2, dm, c2);
      t1 = asr(sl * sl, 30);
      t2 = asr(so * so, 30);
      cc = asr(c1 * c2, 30);
      a = t1 + asr(cc * t2, 30);
      if (a < 0) a = 0;
      if (a > 64'sh40000000) a = 64'sh40000000;
      ra = floor_root(longint'(a) << 30);
      rb = floor_root((64'h40000000 - a) << 30);
      z = vector_angle(ra, rb);
      crad = (longint'(z) * longint'(PiQ30) + (64'd1 << 29)) >> 30;
      dist_v = (longint'(radius) * crad + (64'd1 << 29)) >> 30;
      if (dist_v > DistMax) dist_v = DistMax;
      w.range_nm = dist_v[25:0];
      w.near = dist_v < limit;
      pending.push_back(w);
    endfunction

    function void check_word(logic [31:0] data);
      dist_word_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word %h", data);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (data[25:0] !== e.range_nm || data[26] !== e.near || data[31:27] !== 5'd0) begin
        errors++;
        if (errors <= 10)
          $display("word %0d: exp dist %0d near %0b, got dist %0d near %0b fill %h",
                   checked, e.range_nm, e.near, data[25:0], data[26], data[31:27]);
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i = '0;
  logic [23:0]  cfg_data_i = '0;

  dist_scoreboard sb = new();
  longint unsigned cycles = 0;
  int max_gap = 15;
  int max_stall = 15;
  int unsigned sent = 0;

  haversine_distance_proximity_unit #(.CORDIC_STEPS(Steps)) u_top (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, sb.pending.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);

  initial begin
    int w;
    @(negedge clk_i);
    forever begin
      w = max_stall == 0 ? 0 : $urandom_range(0, max_stall);
      m_axis_tready <= (w == 0);
      repeat (w) @(negedge clk_i);
      m_axis_tready <= 1;
      @(posedge clk_i);
      while (!(m_axis_tvalid)) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [23:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 0;
    if (idx == RegRadius) sb.radius = val;
    else sb.limit = val;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);
  endtask

  task automatic send_pair(logic [31:0] lat1, logic [31:0] lon1,
                           logic [31:0] lat2, logic [31:0] lon2);
    int g;
    g = max_gap == 0 ? 0 : $urandom_range(0, max_gap);
    if (g != 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tdata <= {lon2, lat2, lon1, lat1};
    s_axis_tvalid <= 1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pair(lat1, lon1, lat2, lon2);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_lat();
    return 32'($signed($urandom_range(0, 32'h80000000)) - 32'sh40000000);
  endfunction

  task automatic random_pairs(int n);
    logic [31:0] la, lo;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: send_pair($urandom, $urandom, $urandom, $urandom);
        1: begin
          la = rand_lat(); lo = $urandom;
          send_pair(la, lo, la + $urandom_range(0, 4000) - 2000,
                    lo + $urandom_range(0, 4000) - 2000);
        end
        2: begin
          la = rand_lat(); lo = $urandom;
          send_pair(la, lo, -la, lo ^ 32'h80000000);
        end
        default: send_pair(rand_lat(), $urandom, rand_lat(), $urandom);
      endcase
    end
    s_axis_tvalid <= 0;
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    send_pair(0, 0, 0, 0);
    send_pair(0, 0, 0, 10);
    send_pair(32'h40000000, 0, 32'hC0000000, 0);
    send_pair(32'hC0000000, 32'h7FFFFFFF, 32'h40000000, 32'h80000000);
    send_pair(0, 32'h80000000, 0, 32'h7FFFFFFF);
    send_pair(0, 0, 0, 32'h80000000);
    send_pair(32'h40000000, 0, 32'h40000000, 32'h80000000);
    send_pair(32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, 0);
    send_pair(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h00000001);
    send_pair(32'h20000000, 32'h12345678, 32'h20000100, 32'h12345678);
    send_pair(32'h3FFFFFFF, 32'h40000000, 32'hBFFFFFFF, 32'hC0000000);
    s_axis_tvalid <= 0;
    drain();
    write_reg(RegRadius, 24'hFFFFFF);
    write_reg(RegLimit, 24'hFFFFFF);
    send_pair(0, 0, 0, 32'h80000000);
    send_pair(0, 0, 0, 32'h40000000);
    random_pairs(300);
    drain();
    write_reg(RegRadius, 24'd0);
    write_reg(RegLimit, 24'd0);
    random_pairs(150);
    drain();
    write_reg(RegRadius, 24'd3522627);
    write_reg(RegLimit, 24'd5000);
    max_gap = 0; max_stall = 0;
    random_pairs(350);
    drain();
    max_gap = 15; max_stall = 15;
    write_reg(RegRadius, 24'($urandom_range(1, 24'hFFFFFF)));
    write_reg(RegLimit, 24'($urandom_range(0, 24'h3FFFFF)));
    random_pairs(350);
    max_gap = 2; max_stall = 0;
    random_pairs(350);
    drain();
    $display("%0d position pairs sent, %0d results checked over five register settings",
             sent, sb.checked);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

[haversine_distance_proximity_unit.f]
hdl/hdp_pkg.sv
hdl/hdp_cordic_step.sv
hdl/hdp_sqrt_step.sv
hdl/haversine_distance_proximity_unit.sv
hdl/hdp_checker.sv
bench/tb.sv
